// ===== rtl/relocation_bitstream_encoder_top_defines.svh =====
// Assertion macros shared by the encoder modules.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef RELOCATION_BITSTREAM_ENCODER_TOP_DEFINES_SVH
`define RELOCATION_BITSTREAM_ENCODER_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define RBE_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define RBE_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rbe_pkg.sv =====
package rbe_pkg;

  localparam int BYTE_W      = 8;
  localparam int OFFSET_W    = 16;
  localparam int POS_W       = 16;
  localparam int COUNT_W     = 17;
  // Largest chunk: 19-bit relocation code plus the 3-bit end code.
  localparam int BITS_W      = 22;
  localparam int NBITS_W     = 5;
  // Up to 7 bits left when a chunk is merged in, plus the largest chunk.
  localparam int ACC_W       = 29;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [POS_W-1:0]    MAX_MODULE_BYTES = 16'd58240;
  localparam logic [OFFSET_W-1:0] RELOC_RESET      = 16'd6037;

  localparam logic [NBITS_W-1:0]  LIT_BITS   = 5'd9;
  localparam logic [NBITS_W-1:0]  RELOC_BITS = 5'd19;
  localparam logic [NBITS_W-1:0]  END_BITS   = 5'd3;
  localparam logic [2:0]          END_CODE   = 3'b110;
  localparam logic [2:0]          RELOC_CODE = 3'b100;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIFF = 2'd1;
  localparam logic [1:0] ERR_END  = 2'd2;
  localparam logic [1:0] ERR_LONG = 2'd3;

  // One unit of work for the packer: either a chunk of stream bits or an error.
  typedef struct packed {
    logic               is_err;
    logic [1:0]         err;
    logic               fin;
    logic [NBITS_W-1:0] nbits;
    logic [BITS_W-1:0]  bits;
  } rbe_entry_t;

endpackage

// ===== rtl/rbe_front.sv =====
module rbe_front import rbe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [OFFSET_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   byte_base,
  input  logic [BYTE_W-1:0]   byte_shifted,
  input  logic                last_byte,
  input  logic                q_full,
  output logic                q_push,
  output rbe_entry_t          q_data
);

  logic [OFFSET_W-1:0] reloc_offset;
  logic [POS_W-1:0]    position;
  logic                pend_valid;
  logic [BYTE_W-1:0]   pend_base;
  logic [BYTE_W-1:0]   pend_shifted;
  logic                stopped;

  logic                accept;
  logic                too_long;
  logic                mismatch;
  logic                bad_diff;
  logic                item_err;
  logic                hold;
  logic [1:0]          err_code;
  logic [POS_W-1:0]    low_pos;
  logic [15:0]         word_base;
  logic [15:0]         word_shifted;
  logic [16:0]         diff;
  logic [15:0]         rel;
  logic [18:0]         body_bits;
  logic [NBITS_W-1:0]  body_nbits;

  assign in_ready = stopped || !q_full;
  assign accept   = in_valid && in_ready;

  always_comb begin
    too_long     = position >= MAX_MODULE_BYTES;
    mismatch     = byte_base != byte_shifted;
    low_pos      = position - 16'd1;
    word_base    = {byte_base, pend_base};
    word_shifted = {byte_shifted, pend_shifted};
    diff         = {1'b0, word_shifted} - {1'b0, word_base};
    bad_diff     = diff[16] || (diff[15:0] != reloc_offset);
    rel          = word_base - low_pos;

    item_err   = 1'b0;
    err_code   = ERR_NONE;
    hold       = 1'b0;
    body_bits  = {10'd0, 1'b0, byte_base};
    body_nbits = LIT_BITS;
    if (too_long) begin
      item_err = 1'b1;
      err_code = ERR_LONG;
    end else if (pend_valid) begin
      if (bad_diff) begin
        item_err = 1'b1;
        err_code = ERR_DIFF;
      end
      body_bits  = {RELOC_CODE, rel[7:0], rel[15:8]};
      body_nbits = RELOC_BITS;
    end else if (mismatch) begin
      if (last_byte) begin
        item_err = 1'b1;
        err_code = ERR_END;
      end else begin
        hold = 1'b1;
      end
    end

    q_data.is_err = item_err;
    q_data.err    = err_code;
    q_data.fin    = last_byte && !item_err;
    if (last_byte) begin
      q_data.bits  = {body_bits, END_CODE};
      q_data.nbits = body_nbits + END_BITS;
    end else begin
      q_data.bits  = {3'b000, body_bits};
      q_data.nbits = body_nbits;
    end
  end

  assign q_push = accept && !stopped && !hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      reloc_offset <= RELOC_RESET;
      position     <= '0;
      pend_valid   <= 1'b0;
      stopped      <= 1'b0;
    end else begin
      if (cfg_we) begin
        reloc_offset <= cfg_wdata;
      end
      if (accept && !stopped) begin
        if (item_err || last_byte) begin
          stopped <= 1'b1;
        end
        position   <= position + 16'd1;
        pend_valid <= hold;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && !stopped && !pend_valid) begin
      pend_base    <= byte_base;
      pend_shifted <= byte_shifted;
    end
  end

endmodule

// ===== rtl/rbe_fifo.sv =====
`include "relocation_bitstream_encoder_top_defines.svh"

module rbe_fifo import rbe_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  rbe_entry_t push_data,
  input  logic       pop,
  output rbe_entry_t head,
  output logic       full,
  output logic       empty
);

  rbe_entry_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QUEUE_DEPTH);
  assign empty = count == '0;
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  `RBE_ASSERT_IMP(a_push_not_full, push, !full, "queue written while full")
  `RBE_ASSERT_IMP(a_pop_not_empty, pop, !empty, "queue read while empty")

endmodule

// ===== rtl/rbe_back.sv =====
`include "relocation_bitstream_encoder_top_defines.svh"

module rbe_back import rbe_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  rbe_entry_t         q_head,
  output logic               q_pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [BYTE_W-1:0]  out_byte,
  output logic               out_last,
  output logic [1:0]         out_err,
  output logic [COUNT_W-1:0] out_count
);

  logic [ACC_W-1:0]   acc;
  logic [NBITS_W-1:0] cnt;
  logic               fin;
  logic [COUNT_W-1:0] emitted;

  logic               out_free;
  logic               have_byte;
  logic               head_ok;
  logic               emit_byte;
  logic               emit_pad;
  logic               emit_err;
  logic               load;
  logic [NBITS_W-1:0] shift;
  logic [BYTE_W-1:0]  byte_val;
  logic [BYTE_W-1:0]  pad_val;
  logic [NBITS_W-1:0] cnt_left;

  always_comb begin
    out_free  = !out_valid || out_ready;
    have_byte = cnt >= 5'd8;
    head_ok   = !q_empty && !fin;
    emit_byte = out_free && have_byte;
    emit_pad  = out_free && !have_byte && fin && (cnt != '0);
    emit_err  = out_free && !have_byte && head_ok && q_head.is_err;
    load      = head_ok && !q_head.is_err && (have_byte ? (emit_byte && cnt < 5'd16) : 1'b1);
    q_pop     = load || emit_err;

    shift    = cnt - 5'd8;
    byte_val = BYTE_W'(acc >> shift);
    pad_val  = BYTE_W'(acc[7:0] << (4'd8 - {1'b0, cnt[2:0]}));

    if (emit_byte) begin
      cnt_left = cnt - 5'd8;
    end else if (emit_pad) begin
      cnt_left = '0;
    end else begin
      cnt_left = cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= '0;
      cnt       <= '0;
      fin       <= 1'b0;
      emitted   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        acc <= (acc << q_head.nbits) | ACC_W'(q_head.bits);
        cnt <= cnt_left + q_head.nbits;
        fin <= q_head.fin;
      end else begin
        cnt <= cnt_left;
        if (emit_pad || (emit_byte && fin && cnt == 5'd8)) begin
          fin <= 1'b0;
        end
      end
      if (emit_byte || emit_pad) begin
        emitted <= emitted + 1'b1;
      end
      if (out_free) begin
        out_valid <= emit_byte || emit_pad || emit_err;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (emit_err) begin
        out_byte  <= '0;
        out_last  <= 1'b1;
        out_err   <= q_head.err;
        out_count <= emitted;
      end else begin
        out_byte  <= emit_pad ? pad_val : byte_val;
        out_last  <= emit_pad || (fin && cnt == 5'd8);
        out_err   <= ERR_NONE;
        out_count <= emitted + 1'b1;
      end
    end
  end

  `RBE_ASSERT_IMP(a_fin_blocks_load, fin, !load, "chunk loaded after the end code")
  `RBE_ASSERT_NXT(a_pad_closes, emit_pad, !fin && cnt == '0, "pad byte left bits behind")

endmodule

// ===== rtl/relocation_bitstream_encoder_top.sv =====
// Channel   Handshake             Payload
// input     in_valid / in_ready   byte_base, byte_shifted, last_byte
// output    out_valid / out_ready out_byte, out_last, error_code, out_count
// config    cfg_we                cfg_wdata (reloc_offset, no wait)
//
// The front end takes one byte pair per cycle while the four-entry queue has
// room; a held mismatch or an item arriving after the stream has ended is
// taken without adding anything to the queue.
// The bit packer sends at most one stream byte per cycle through its
// output register, so that port sets the sustained rate, as each item
// yields 9 or about 9.5 stream bits.
// Reset (rst, synchronous, active high) clears the stream state and loads
// reloc_offset with 6037. Either side may stall without losing a transfer.
module relocation_bitstream_encoder_top import rbe_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [OFFSET_W-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BYTE_W-1:0]   byte_base,
  input  logic [BYTE_W-1:0]   byte_shifted,
  input  logic                last_byte,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_byte,
  output logic                out_last,
  output logic [1:0]          error_code,
  output logic [COUNT_W-1:0]  out_count
);

  // Work items travel from the classifier to the packer through this queue.
  logic       q_push;
  logic       q_pop;
  logic       q_full;
  logic       q_empty;
  rbe_entry_t q_wdata;
  rbe_entry_t q_head;

  // The front end tracks position and the held half of a relocated word, and
  // turns each transfer that it neither holds nor drops into a bit chunk
  // (literal, relocation code, optional end code) or an error marker.
  rbe_front u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_base    (byte_base),
    .byte_shifted (byte_shifted),
    .last_byte    (last_byte),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_data       (q_wdata)
  );

  rbe_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .head      (q_head),
    .full      (q_full),
    .empty     (q_empty)
  );

  // The packer shifts chunks into a bit accumulator and drains it MSB first,
  // padding the final byte with zeros and counting every byte sent.
  rbe_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_byte  (out_byte),
    .out_last  (out_last),
    .out_err   (error_code),
    .out_count (out_count)
  );

endmodule

// ===== dv/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rbe_pkg::*;

  // Cycles allowed for the block to settle after the last expected byte.
  // A held mismatch yields no stream byte, so this pause comes before
  // every offset write.
  localparam int LAT_CYCLES     = 16;
  // The receiver holds off this long once, so that the four-entry queue
  // fills up and the block has to drop in_ready.
  localparam int LONG_HOLD      = 120;
  // Cycles without a single transfer on either channel before giving up.
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int N_DIR          = 14;

  // One expected stream byte, in the order the block has to send it.
  typedef struct packed {
    logic [BYTE_W-1:0]  data;
    logic               last;
    logic [1:0]         err;
    logic [COUNT_W-1:0] count;
  } stream_rec_t;

  // One row of the directed table. Rows with has_ref set carry the first
  // stream byte of the item, typed in by hand.
  typedef struct packed {
    logic [BYTE_W-1:0]  base;
    logic [BYTE_W-1:0]  shifted;
    logic               has_ref;
    logic [BYTE_W-1:0]  ref_data;
    logic [COUNT_W-1:0] ref_count;
  } dir_row_t;

  // Ways the one stream of the run can end. Only one of them fits in a run,
  // because the block stays stopped until a reset, so the seed picks it.
  typedef enum int {
    FIN_LITERAL,
    FIN_WORD,
    FIN_LAST_MISMATCH,
    FIN_DIFF_BELOW,
    FIN_DIFF_WRONG,
    FIN_DIFF_ZERO_OFFSET
  } stream_end_t;

  localparam stream_rec_t NO_REF = '0;

  logic                clk = 1'b0;
  logic                rst;
  logic                cfg_we;
  logic [OFFSET_W-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [BYTE_W-1:0]   byte_base;
  logic [BYTE_W-1:0]   byte_shifted;
  logic                last_byte;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [BYTE_W-1:0]   out_byte;
  logic                out_last;
  logic [1:0]          error_code;
  logic [COUNT_W-1:0]  out_count;

  relocation_bitstream_encoder_top u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .byte_base    (byte_base),
    .byte_shifted (byte_shifted),
    .last_byte    (last_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_byte     (out_byte),
    .out_last     (out_last),
    .error_code   (error_code),
    .out_count    (out_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expected stream bytes not yet seen on the output, oldest first, and the
  // bytes that the item being accepted right now adds to them.
  stream_rec_t stream_q[$];
  stream_rec_t step_q[$];

  // Encoder state as the testbench tracks it.
  logic [63:0]         bit_acc;
  int                  bit_cnt;
  logic [POS_W-1:0]    mod_pos;
  bit                  held_v;
  logic [BYTE_W-1:0]   held_base;
  logic [BYTE_W-1:0]   held_shift;
  bit                  stream_done;
  logic [COUNT_W-1:0]  bytes_out;
  logic [OFFSET_W-1:0] offset_q;

  int n_fail        = 0;
  bit idle_on       = 1'b1;
  bit long_hold_req = 1'b0;
  int rx_hold       = 0;
  int stall_cycles  = 0;

  dir_row_t dir_rows [N_DIR] = '{
    // Right after reset: a literal 0xFF gives 0,1111111 as the first byte,
    // and a literal 0x00 then flushes the leftover 1 as 0x80.
    '{8'hFF, 8'hFF, 1'b1, 8'h7F, 17'd1},
    '{8'h00, 8'h00, 1'b1, 8'h80, 17'd2},
    // Relocated words at the reset offset 0x1795: lowest base word, highest
    // base word, a carry out of the low byte, and an ordinary one.
    '{8'h00, 8'h95, 1'b0, 8'h00, 17'd0},
    '{8'h00, 8'h17, 1'b0, 8'h00, 17'd0},
    '{8'h6A, 8'hFF, 1'b0, 8'h00, 17'd0},
    '{8'hE8, 8'hFF, 1'b0, 8'h00, 17'd0},
    '{8'hF0, 8'h85, 1'b0, 8'h00, 17'd0},
    '{8'h00, 8'h18, 1'b0, 8'h00, 17'd0},
    '{8'h34, 8'hC9, 1'b0, 8'h00, 17'd0},
    '{8'h12, 8'h29, 1'b0, 8'h00, 17'd0},
    // Literals with alternating and single-bit patterns.
    '{8'h55, 8'h55, 1'b0, 8'h00, 17'd0},
    '{8'hAA, 8'hAA, 1'b0, 8'h00, 17'd0},
    '{8'h80, 8'h80, 1'b0, 8'h00, 17'd0},
    '{8'h01, 8'h01, 1'b0, 8'h00, 17'd0}
  };

  function automatic void append_bits(input logic [31:0] value, input int nbits);
    bit_acc = (bit_acc << nbits) | 64'(value);
    bit_cnt += nbits;
  endfunction

  function automatic void emit_byte(input logic [BYTE_W-1:0] b);
    bytes_out = bytes_out + 17'd1;
    step_q.push_back('{data: b, last: 1'b0, err: ERR_NONE, count: bytes_out});
  endfunction

  function automatic void flush_bytes();
    while (bit_cnt >= 8) begin
      emit_byte(8'(bit_acc >> (bit_cnt - 8)));
      bit_cnt -= 8;
    end
  endfunction

  function automatic void raise_error(input logic [1:0] code);
    stream_done = 1'b1;
    step_q.push_back('{data: 8'h00, last: 1'b1, err: code, count: bytes_out});
  endfunction

  // Works out the stream bytes that one accepted byte pair releases, into
  // step_q, and moves the tracked encoder state on.
  function automatic void encode_pair(input logic [BYTE_W-1:0] bb, input logic [BYTE_W-1:0] bs,
                                      input logic lst);
    logic [15:0] w_base;
    logic [15:0] w_shift;
    logic [15:0] rel;
    step_q.delete();
    if (stream_done) return;
    // The length check wins over everything else, even a last byte.
    if (mod_pos >= MAX_MODULE_BYTES) begin
      raise_error(ERR_LONG);
      return;
    end
    if (held_v) begin
      // The high-byte pair completes the held word and is never compared
      // on its own.
      w_base  = {bb, held_base};
      w_shift = {bs, held_shift};
      held_v  = 1'b0;
      if (w_shift < w_base || (w_shift - w_base) != offset_q) begin
        raise_error(ERR_DIFF);
        return;
      end
      rel = w_base - (mod_pos - 16'd1);
      append_bits(32'({RELOC_CODE, rel[7:0], rel[15:8]}), 19);
    end else if (bb != bs) begin
      if (lst) begin
        raise_error(ERR_END);
        return;
      end
      held_v     = 1'b1;
      held_base  = bb;
      held_shift = bs;
    end else begin
      append_bits(32'({1'b0, bb}), 9);
    end
    mod_pos = mod_pos + 16'd1;
    if (lst) begin
      append_bits(32'(END_CODE), 3);
      flush_bytes();
      if (bit_cnt != 0) begin
        emit_byte(8'(bit_acc << (8 - bit_cnt)));
        bit_cnt = 0;
      end
      step_q[step_q.size() - 1].last = 1'b1;
      stream_done = 1'b1;
    end else begin
      flush_bytes();
    end
  endfunction

  // Offers one byte pair and waits for its transfer. Called at a rising
  // edge; the pair may be preceded by a short burst with valid low. On a
  // directed row with a typed-in byte, that byte replaces the first one
  // worked out here.
  task automatic send_pair(input logic [BYTE_W-1:0] bb, input logic [BYTE_W-1:0] bs,
                           input logic lst, input logic has_ref, input stream_rec_t ref_rec);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid     <= 1'b1;
    byte_base    <= bb;
    byte_shifted <= bs;
    last_byte    <= lst;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    encode_pair(bb, bs, lst);
    if (has_ref && step_q.size() != 0) step_q[0] = ref_rec;
    foreach (step_q[i]) stream_q.push_back(step_q[i]);
  endtask

  task automatic send_word(input logic [15:0] w_base, input logic [15:0] w_shift,
                           input logic lst);
    send_pair(w_base[7:0], w_shift[7:0], 1'b0, 1'b0, NO_REF);
    send_pair(w_base[15:8], w_shift[15:8], lst, 1'b0, NO_REF);
  endtask

  // Well-formed module content: literals and relocated words at the current
  // offset. Words always go out whole, so a run never ends on a held byte.
  task automatic send_random_run(input int n_items);
    int          sent;
    logic [15:0] w_base;
    logic [7:0]  b;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(0, 2) == 0) begin
        w_base = 16'($urandom_range(0, 16'hFFFF - int'(offset_q)));
        send_word(w_base, w_base + offset_q, 1'b0);
        sent += 2;
      end else begin
        b = 8'($urandom);
        send_pair(b, b, 1'b0, 1'b0, NO_REF);
        sent++;
      end
    end
  endtask

  // The offset may only change while the block is idle, so the sender
  // stops, every expected byte has to come out, and the block gets a few
  // more cycles before the write.
  task automatic set_offset(input logic [OFFSET_W-1:0] value);
    in_valid <= 1'b0;
    while (stream_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    offset_q  = value;
  endtask

  // Receiver: checks each output transfer against the oldest expected byte
  // and then decides out_ready for the next cycle. Stalls come in short
  // random bursts, plus one long hold-off when the sender asks for it.
  always @(posedge clk) begin : rx_side
    stream_rec_t want;
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (stream_q.size() == 0) begin
          $error("stream byte %0h arrived with no expected byte waiting", out_byte);
          n_fail++;
        end else begin
          want = stream_q.pop_front();
          if (out_byte !== want.data) begin
            $error("out_byte: expected %0h, actual %0h", want.data, out_byte);
            n_fail++;
          end
          if (out_last !== want.last) begin
            $error("out_last: expected %0d, actual %0d", want.last, out_last);
            n_fail++;
          end
          if (error_code !== want.err) begin
            $error("error_code: expected %0d, actual %0d", want.err, error_code);
            n_fail++;
          end
          if (out_count !== want.count) begin
            $error("out_count: expected %0d, actual %0d", want.count, out_count);
            n_fail++;
          end
        end
      end
      if (rx_hold > 0) begin
        rx_hold--;
        out_ready <= 1'b0;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        rx_hold = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        rx_hold = $urandom_range(0, 5);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: any transfer on either channel resets the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin : stimulus
    logic [OFFSET_W-1:0] rnd_offset;
    logic [15:0]         w_base;
    logic [15:0]         w_shift;
    logic [7:0]          b;
    int                  delta;
    stream_end_t         ending;

    rst          <= 1'b1;
    cfg_we       <= 1'b0;
    cfg_wdata    <= '0;
    in_valid     <= 1'b0;
    byte_base    <= '0;
    byte_shifted <= '0;
    last_byte    <= 1'b0;

    bit_acc     = '0;
    bit_cnt     = 0;
    mod_pos     = '0;
    held_v      = 1'b0;
    held_base   = '0;
    held_shift  = '0;
    stream_done = 1'b0;
    bytes_out   = '0;
    offset_q    = RELOC_RESET;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Directed rows at the reset offset. None of them ends the stream: the
    // whole run is one module, so the ending comes last.
    foreach (dir_rows[i]) begin
      send_pair(dir_rows[i].base, dir_rows[i].shifted, 1'b0, dir_rows[i].has_ref,
                '{data: dir_rows[i].ref_data, last: 1'b0, err: ERR_NONE,
                  count: dir_rows[i].ref_count});
    end
    send_random_run(60);

    // Smallest offset. Partway in, the receiver stops for a long stretch
    // while the sender keeps offering pairs.
    set_offset(16'd1);
    send_random_run(10);
    long_hold_req = 1'b1;
    send_random_run(50);

    // Largest offset, where the only relocatable word is 0x0000 against
    // 0xFFFF, and a stretch with no idling on either side.
    set_offset(16'hFFFF);
    idle_on = 1'b0;
    send_random_run(50);
    idle_on = 1'b1;

    // Random offsets. A multiple of 256 would make the low bytes of a word
    // match, so those are nudged off.
    repeat (2) begin
      rnd_offset = 16'($urandom_range(1, 16'hFFFF));
      if (rnd_offset[7:0] == 8'h00) rnd_offset[0] = 1'b1;
      set_offset(rnd_offset);
      send_random_run(70);
    end

    // The end of the stream, with no idling from here on.
    idle_on = 1'b0;
    ending = stream_end_t'($urandom_range(0, 5));
    case (ending)
      FIN_LITERAL: begin
        b = 8'($urandom);
        send_pair(b, b, 1'b1, 1'b0, NO_REF);
      end
      FIN_WORD: begin
        // The flag on the pair that completes a word still ends the stream.
        w_base = 16'($urandom_range(0, 16'hFFFF - int'(offset_q)));
        send_word(w_base, w_base + offset_q, 1'b1);
      end
      FIN_LAST_MISMATCH: begin
        b = 8'($urandom);
        send_pair(b, b ^ 8'($urandom_range(1, 255)), 1'b1, 1'b0, NO_REF);
      end
      FIN_DIFF_BELOW: begin
        // Shifted word below the base word. With equal low bytes the high
        // byte is already smaller, so flipping a low bit keeps it below.
        w_base  = 16'($urandom_range(1, 16'hFFFF));
        w_shift = 16'($urandom_range(0, int'(w_base) - 1));
        if (w_shift[7:0] == w_base[7:0]) w_shift[0] = ~w_shift[0];
        send_word(w_base, w_shift, 1'($urandom));
      end
      FIN_DIFF_WRONG, FIN_DIFF_ZERO_OFFSET: begin
        // With a zero offset no word can match, since its low bytes differ.
        if (ending == FIN_DIFF_ZERO_OFFSET) set_offset(16'd0);
        delta = $urandom_range(1, 255);
        if (delta == int'(offset_q)) delta = (delta == 255) ? 254 : delta + 1;
        w_base = 16'($urandom_range(0, 16'hFFFF - delta));
        send_word(w_base, w_base + 16'(delta), 1'($urandom));
      end
      default: begin
        $error("ending: expected a known stream ending, actual %0d", ending);
        n_fail++;
      end
    endcase

    // Once stopped, the block must take these without a single stream byte.
    repeat (4) send_pair(8'($urandom), 8'($urandom), 1'($urandom), 1'b0, NO_REF);
    in_valid <= 1'b0;

    while (stream_q.size() != 0) @(posedge clk);
    repeat (LAT_CYCLES * 2) @(posedge clk);
    if (n_fail == 0 && stream_q.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== relocation_bitstream_encoder_top.f =====
+incdir+rtl
rtl/rbe_pkg.sv
rtl/rbe_front.sv
rtl/rbe_fifo.sv
rtl/rbe_back.sv
rtl/relocation_bitstream_encoder_top.sv
dv/tb_top.sv
